>>> design/temperature_average_alarm_defines.svh
// Assertion macros used by the temperature alarm top level.
`ifndef TEMPERATURE_AVERAGE_ALARM_DEFINES_SVH
`define TEMPERATURE_AVERAGE_ALARM_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define TAV_ASSERT_NOW(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// Condition must hold in the cycle after the trigger.
`define TAV_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

>>> design/tav_pkg.sv
// Shared types and constants for the temperature average alarm.
package tav_pkg;

  localparam int MAX_WINDOW_DEF = 16;
  localparam int ADC_BITS_DEF   = 10;

  localparam int CELSIUS_W = 17;
  localparam int THRESH_W  = 11;
  localparam int WIN_W     = 5;
  localparam int CMD_W     = 2;
  localparam int CFG_W     = 11;
  localparam int OUT_W     = 48;

  // Twice the full scale in 1/256 degree, for round-half-up scaling.
  localparam int SCALE_MUL    = 256000;
  localparam int THRESH_MAX   = 1000;
  localparam int THRESH_RESET = 70;
  localparam int WINDOW_RESET = 10;
  localparam int FLOOR_RESET  = -20;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_UP     = 2'd1,
    CMD_DOWN   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_WINDOW = 1'b0,
    REG_FLOOR  = 1'b1
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SCALE_WAIT,
    ST_SUB,
    ST_ADD,
    ST_AVG,
    ST_AVG_WAIT,
    ST_THRESH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> design/temperature_average_alarm.sv
// Top level: moving-average temperature alarm with serial scaling and averaging.
//
// Input stream s_*: s_tuser carries the command (sample, threshold up,
// threshold down), s_tdata the raw converter reading. Output stream m_*:
// one result transaction per accepted input, carrying the latest scaled
// sample, the moving average, the current threshold and the alarm flag.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 window
// length, 1 threshold floor); writing the window length empties the averager.
// For a sample, the bit-serial divider runs once to scale the reading and
// once to divide the running sum by the fill count. A threshold command's
// result does not use the divider. One item is in work at a time; the
// next one is accepted the cycle after the previous one has moved into
// the output register, even while that result still waits on m_tready.
// When the receiver stalls, the result holds in the output register and a
// finished item that has no room waits in its last step.
// Reset (rst, synchronous) empties the averager, sets the threshold to 35.0
// degrees, the window to 10 samples and the floor to -10.0 degrees.
`include "temperature_average_alarm_defines.svh"

module temperature_average_alarm #(
  parameter int MAX_WINDOW = tav_pkg::MAX_WINDOW_DEF,
  parameter int ADC_BITS   = tav_pkg::ADC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [((ADC_BITS+7)/8)*8-1:0] s_tdata,  // adc_sample
  input  logic [tav_pkg::CMD_W-1:0]   s_tuser,    // cmd
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // raw_celsius[16:0], avg_celsius[33:17], alarm_threshold[44:34], alarm_active[45]
  output logic [tav_pkg::OUT_W-1:0]   m_tdata,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [tav_pkg::CFG_W-1:0]   cfg_data
);

  localparam int C_W        = tav_pkg::CELSIUS_W;
  localparam int T_W        = tav_pkg::THRESH_W;
  localparam int ADC_FULL   = (1 << ADC_BITS) - 1;
  localparam int SAMPLE_DEN = 2 * ADC_FULL;
  localparam int IDX_W      = $clog2(MAX_WINDOW);
  localparam int FILL_W     = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W      = C_W + $clog2(MAX_WINDOW);
  localparam int SCL_W      = ADC_BITS + 18;
  localparam int NUM_W      = (SCL_W > SUM_W) ? SCL_W : SUM_W;
  localparam int DEN_W      = (ADC_BITS + 1 > FILL_W) ? ADC_BITS + 1 : FILL_W;

  tav_pkg::state_t state, state_next;

  logic [tav_pkg::WIN_W-1:0] window_length;
  logic signed [T_W-1:0]     threshold_floor;
  logic signed [T_W-1:0]     threshold;
  logic [IDX_W-1:0]          write_index;
  logic [FILL_W-1:0]         fill_count;
  logic [SUM_W-1:0]          running_sum;
  logic [C_W-1:0]            last_sample;
  logic [C_W-1:0]            last_average;
  logic [ADC_BITS-1:0]       adc_reg;
  tav_pkg::cmd_t             cmd_reg;
  logic [IDX_W-1:0]          idx_reg;
  logic [C_W-1:0]            c_reg;
  logic [C_W-1:0]            rd_data;
  logic [C_W-1:0]            ring [MAX_WINDOW];

  logic [FILL_W-1:0]         win_eff;
  logic [FILL_W-1:0]         idx_inc;
  logic signed [T_W-1:0]     floor_eff;
  logic signed [T_W:0]       thresh_dec;
  logic signed [T_W+9:0]     avg_x2;
  logic signed [T_W+9:0]     thresh_x256;
  logic                      alarm;

  logic                      in_take;
  logic                      div_start;
  logic                      out_load;
  logic [NUM_W-1:0]          div_num;
  logic [DEN_W-1:0]          div_den;
  logic [NUM_W-1:0]          div_quo;
  tav_pkg::div_stat_t        div_stat;

  tav_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  // Clamp the window register to 1..MAX_WINDOW.
  always_comb begin
    if (window_length == '0) begin
      win_eff = FILL_W'(1);
    end else if (32'(window_length) > MAX_WINDOW) begin
      win_eff = FILL_W'(MAX_WINDOW);
    end else begin
      win_eff = FILL_W'(window_length);
    end
  end

  assign idx_inc     = FILL_W'(idx_reg) + FILL_W'(1);
  assign floor_eff   = (threshold_floor > T_W'(tav_pkg::THRESH_MAX)) ?
                       T_W'(tav_pkg::THRESH_MAX) : threshold_floor;
  assign thresh_dec  = {threshold[T_W-1], threshold} - (T_W+1)'(1);
  assign avg_x2      = $signed({3'b000, last_average, 1'b0});
  assign thresh_x256 = $signed({{2{threshold[T_W-1]}}, threshold, 8'h00});
  assign alarm       = (fill_count != '0) && (avg_x2 >= thresh_x256);

  always_comb begin
    if (state == tav_pkg::ST_SCALE) begin
      div_num = NUM_W'(adc_reg) * NUM_W'(tav_pkg::SCALE_MUL) + NUM_W'(ADC_FULL);
      div_den = DEN_W'(SAMPLE_DEN);
    end else begin
      div_num = NUM_W'(running_sum);
      div_den = DEN_W'(fill_count);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      tav_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (tav_pkg::cmd_t'(s_tuser) == tav_pkg::CMD_SAMPLE) ?
                       tav_pkg::ST_SCALE : tav_pkg::ST_THRESH;
        end
      end
      tav_pkg::ST_SCALE:      state_next = tav_pkg::ST_SCALE_WAIT;
      tav_pkg::ST_SCALE_WAIT: if (div_stat.done) state_next = tav_pkg::ST_SUB;
      tav_pkg::ST_SUB:        state_next = tav_pkg::ST_ADD;
      tav_pkg::ST_ADD:        state_next = tav_pkg::ST_AVG;
      tav_pkg::ST_AVG:        state_next = tav_pkg::ST_AVG_WAIT;
      tav_pkg::ST_AVG_WAIT:   if (div_stat.done) state_next = tav_pkg::ST_DONE;
      tav_pkg::ST_THRESH:     state_next = tav_pkg::ST_DONE;
      tav_pkg::ST_DONE:       if (!m_tvalid || m_tready) state_next = tav_pkg::ST_IDLE;
      default:                state_next = tav_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    s_tready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      tav_pkg::ST_IDLE:  s_tready  = 1'b1;
      tav_pkg::ST_SCALE: div_start = 1'b1;
      tav_pkg::ST_AVG:   div_start = 1'b1;
      tav_pkg::ST_DONE:  out_load  = !m_tvalid || m_tready;
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  assign in_take = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= tav_pkg::ST_IDLE;
      window_length   <= tav_pkg::WIN_W'(tav_pkg::WINDOW_RESET);
      threshold_floor <= T_W'(tav_pkg::FLOOR_RESET);
      threshold       <= T_W'(tav_pkg::THRESH_RESET);
      write_index     <= '0;
      fill_count      <= '0;
      running_sum     <= '0;
      last_sample     <= '0;
      last_average    <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (tav_pkg::reg_index_t'(cfg_index))
          tav_pkg::REG_WINDOW: begin
            window_length <= cfg_data[tav_pkg::WIN_W-1:0];
            write_index   <= '0;
            fill_count    <= '0;
            running_sum   <= '0;
          end
          tav_pkg::REG_FLOOR: threshold_floor <= cfg_data;
          default: threshold_floor <= threshold_floor;
        endcase
      end
      case (state)
        tav_pkg::ST_SUB: begin
          // Grow the fill during warm-up, otherwise drop the oldest sample.
          if (fill_count < win_eff) begin
            fill_count <= fill_count + FILL_W'(1);
          end else begin
            running_sum <= running_sum - SUM_W'(rd_data);
          end
        end
        tav_pkg::ST_ADD: begin
          running_sum <= running_sum + SUM_W'(c_reg);
          last_sample <= c_reg;
          write_index <= (idx_inc >= win_eff) ? '0 : IDX_W'(idx_inc);
        end
        tav_pkg::ST_AVG_WAIT: begin
          if (div_stat.done) last_average <= div_quo[C_W-1:0];
        end
        tav_pkg::ST_THRESH: begin
          case (cmd_reg)
            tav_pkg::CMD_UP: begin
              if (threshold < T_W'(tav_pkg::THRESH_MAX)) threshold <= threshold + T_W'(1);
              else threshold <= T_W'(tav_pkg::THRESH_MAX);
            end
            tav_pkg::CMD_DOWN: begin
              if (thresh_dec < $signed({floor_eff[T_W-1], floor_eff})) threshold <= floor_eff;
              else threshold <= thresh_dec[T_W-1:0];
            end
            default: threshold <= threshold;
          endcase
        end
        default: begin
          threshold <= threshold;
        end
      endcase
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      adc_reg <= s_tdata[ADC_BITS-1:0];
      cmd_reg <= tav_pkg::cmd_t'(s_tuser);
      idx_reg <= (FILL_W'(write_index) >= win_eff) ? '0 : write_index;
    end
    if (state == tav_pkg::ST_SCALE_WAIT && div_stat.done) begin
      c_reg <= div_quo[C_W-1:0];
    end
    if (out_load) begin
      m_tdata <= {2'b00, alarm, threshold, last_average, last_sample};
    end
  end

  // Sample ring: read the outgoing entry while scaling, write the new one after.
  always_ff @(posedge clk) begin
    if (state == tav_pkg::ST_SCALE) begin
      rd_data <= ring[idx_reg];
    end
    if (state == tav_pkg::ST_ADD) begin
      ring[idx_reg] <= c_reg;
    end
  end

  `TAV_ASSERT_NOW(a_fill_in_window, 1'b1, fill_count <= win_eff, "fill count exceeds window")
  `TAV_ASSERT_NOW(a_index_in_window, 1'b1, FILL_W'(write_index) < win_eff, "write index past window")
  `TAV_ASSERT_NOW(a_thresh_max, 1'b1, threshold <= T_W'(tav_pkg::THRESH_MAX), "threshold above max")
  `TAV_ASSERT_NOW(a_ready_div_idle, s_tready, !div_stat.busy, "input taken while dividing")
  `TAV_ASSERT_NEXT(a_accept_busy, in_take, !s_tready, "second item taken during work")

endmodule

>>> design/tav_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module tav_div #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 11
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_W-1:0]    num,
  input  logic [DEN_W-1:0]    den,
  output logic [NUM_W-1:0]    quo,
  output tav_pkg::div_stat_t  stat
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_reg;
  logic [NUM_W-1:0] shreg;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   trial;
  logic             fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem, shreg[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      shreg   <= num;
      den_reg <= den;
    end else if (busy) begin
      rem   <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
      shreg <= {shreg[NUM_W-2:0], fits};
    end
  end

  assign quo       = shreg;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

>>> tb/sv/temperature_average_alarm_test.sv
// Self-checking stream testbench for the moving-average temperature alarm.
module temperature_average_alarm_test;
  import tav_pkg::*;

  localparam int TDATA_W = ((ADC_BITS_DEF + 7) / 8) * 8;
  localparam int ADC_FULL = (1 << ADC_BITS_DEF) - 1;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS = 80;

  typedef struct packed {
    cmd_t cmd;
    logic [ADC_BITS_DEF-1:0] adc;
  } sensor_item_t;

  typedef struct packed {
    logic [CELSIUS_W-1:0] raw;
    logic [CELSIUS_W-1:0] avg;
    logic signed [THRESH_W-1:0] thr;
    logic alarm;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;
  logic [CMD_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  reg_index_t cfg_index = REG_WINDOW;
  logic [CFG_W-1:0] cfg_data = '0;

  sensor_item_t pending_q[$];
  reading_t reading_q[$];
  sensor_item_t cur_item = '0;
  bit offering = 1'b0;
  bit offer_taken = 1'b0;
  bit hold_off = 1'b0;
  bit recv_stall = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;
  int send_idle_pct = 15;
  int recv_idle_pct = 15;
  int taken_count = 0;
  int fault_count = 0;

  // Shadow copy of the averager, threshold and registers.
  logic [CELSIUS_W-1:0] ring_mem [MAX_WINDOW_DEF];
  int unsigned ring_wr = 0;
  int unsigned ring_fill = 0;
  int unsigned ring_sum = 0;
  int thr_half = THRESH_RESET;
  logic [CELSIUS_W-1:0] last_raw = '0;
  logic [CELSIUS_W-1:0] last_avg = '0;
  logic [WIN_W-1:0] win_reg = WINDOW_RESET;
  logic signed [THRESH_W-1:0] floor_reg = FLOOR_RESET;

  temperature_average_alarm DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial forever #5 clk = ~clk;

  function automatic reading_t track_reading(cmd_t cmd, logic [ADC_BITS_DEF-1:0] adc);
    int unsigned span;
    int unsigned slot;
    int unsigned scaled;
    int floor_eff;
    reading_t r;
    floor_eff = floor_reg;
    if (floor_eff > THRESH_MAX) floor_eff = THRESH_MAX;
    case (cmd)
      CMD_SAMPLE: begin
        // Round half up: (adc * 2 * full_scale + full) / (2 * full).
        scaled = (int'(adc) * SCALE_MUL + ADC_FULL) / (2 * ADC_FULL);
        span = (win_reg == 0) ? 1 : (win_reg > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : win_reg;
        slot = (ring_wr >= span) ? 0 : ring_wr;
        if (ring_fill < span) ring_fill++;
        else ring_sum -= ring_mem[slot];
        ring_mem[slot] = scaled[CELSIUS_W-1:0];
        ring_sum += scaled;
        ring_wr = (slot + 1 >= span) ? 0 : slot + 1;
        last_raw = scaled[CELSIUS_W-1:0];
        last_avg = CELSIUS_W'(ring_sum / ring_fill);
      end
      CMD_UP: begin
        if (thr_half < THRESH_MAX) thr_half++;
        else thr_half = THRESH_MAX;
      end
      CMD_DOWN: begin
        thr_half--;
        if (thr_half < floor_eff) thr_half = floor_eff;
      end
      default: ;
    endcase
    r.raw = last_raw;
    r.avg = last_avg;
    r.thr = THRESH_W'(thr_half);
    // Average is in 1/256 degree, threshold in half degrees.
    r.alarm = (ring_fill > 0) && (longint'(last_avg) * 2 >= longint'(thr_half) * 256);
    return r;
  endfunction

  function automatic void add_item(cmd_t cmd, int adc);
    sensor_item_t it;
    it.cmd = cmd;
    it.adc = adc[ADC_BITS_DEF-1:0];
    pending_q.push_back(it);
  endfunction

  task automatic write_reg(reg_index_t idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == REG_WINDOW) begin
      win_reg = val[WIN_W-1:0];
      ring_wr = 0;
      ring_fill = 0;
      ring_sum = 0;
    end else begin
      floor_reg = val;
    end
  endtask

  task automatic configure(bit set_window, logic [WIN_W-1:0] win,
                           logic signed [THRESH_W-1:0] flr);
    if (set_window) write_reg(REG_WINDOW, CFG_W'(win));
    write_reg(REG_FLOOR, flr);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (pending_q.size() != 0 || offering || reading_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Sender: hold each transaction until taken, then maybe idle for a burst.
  always @(negedge clk) begin
    if (offer_taken) begin
      offer_taken = 1'b0;
      offering = 1'b0;
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        send_gap = $urandom_range(1, 12);
    end
    if (!offering) begin
      if (send_gap != 0) begin
        send_gap--;
      end else if (pending_q.size() != 0) begin
        cur_item = pending_q.pop_front();
        offering = 1'b1;
      end
    end
    s_tvalid <= offering;
    s_tuser <= cur_item.cmd;
    s_tdata <= TDATA_W'(cur_item.adc);
  end

  // Receiver: random stall bursts plus the long hold-off.
  always @(negedge clk) begin
    if (recv_gap != 0) begin
      recv_gap--;
      recv_stall = 1'b1;
    end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
      recv_gap = $urandom_range(0, 11);
      recv_stall = 1'b1;
    end else begin
      recv_stall = 1'b0;
    end
    m_tready <= !hold_off && !recv_stall;
  end

  always @(posedge clk) begin : watch
    reading_t got;
    reading_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.raw = m_tdata[16:0];
        got.avg = m_tdata[33:17];
        got.thr = m_tdata[44:34];
        got.alarm = m_tdata[45];
        if (reading_q.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("unexpected result: raw %0d avg %0d thr %0d alarm %0b",
                     got.raw, got.avg, got.thr, got.alarm);
        end else begin
          want = reading_q.pop_front();
          if (got.raw !== want.raw || got.avg !== want.avg || got.thr !== want.thr ||
              got.alarm !== want.alarm) begin
            fault_count++;
            if (fault_count <= 10)
              $display("mismatch: expected raw %0d avg %0d thr %0d alarm %0b, got raw %0d avg %0d thr %0d alarm %0b",
                       want.raw, want.avg, want.thr, want.alarm,
                       got.raw, got.avg, got.thr, got.alarm);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        reading_q.push_back(track_reading(cmd_t'(s_tuser), s_tdata[ADC_BITS_DEF-1:0]));
        offer_taken = 1'b1;
        taken_count++;
      end
    end
  end

  // Block the output long enough that the input side backs up.
  initial begin : long_hold
    while (taken_count < 120) @(posedge clk);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin : stimulus
    int warmup_adc [12] = '{0, 1023, 1, 512, 'h2AA, 'h155, 72, 1022, 100, 0, 1023, 1023};
    int floor_pick;
    int win_pick;
    int roll;
    int adc_pick;
    int near;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Empty averager first, then warm-up past the window and wrap.
    add_item(CMD_UP, 0);
    add_item(CMD_NONE, $urandom_range(0, ADC_FULL));
    add_item(CMD_DOWN, ADC_FULL);
    foreach (warmup_adc[i]) add_item(CMD_SAMPLE, warmup_adc[i]);
    add_item(CMD_NONE, 0);
    add_item(CMD_UP, 0);
    add_item(CMD_DOWN, 0);
    settle();

    // Floor above the top: down jumps to the cap, up saturates, average ties.
    configure(1'b1, 1, 1023);
    add_item(CMD_DOWN, 0);
    add_item(CMD_UP, 0);
    add_item(CMD_SAMPLE, 1023);
    add_item(CMD_SAMPLE, 1022);
    add_item(CMD_NONE, 0);
    settle();

    // Window of zero acts as one; lowest floor.
    configure(1'b1, 0, -1024);
    add_item(CMD_SAMPLE, 5);
    add_item(CMD_DOWN, 0);
    add_item(CMD_SAMPLE, 0);
    add_item(CMD_UP, 0);
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 5))
        0: floor_pick = -1024;
        1: floor_pick = 1023;
        2: floor_pick = thr_half - int'($urandom_range(0, 6));
        3: floor_pick = -40;
        4: floor_pick = 1000;
        default: floor_pick = int'($urandom_range(0, 2047)) - 1024;
      endcase
      if (floor_pick < -1024) floor_pick = -1024;
      case ($urandom_range(0, 4))
        0: win_pick = 1;
        1: win_pick = 16;
        2: win_pick = 0;
        3: win_pick = 31;
        default: win_pick = $urandom_range(0, 31);
      endcase
      if (p == 0) win_pick = 31;
      configure(p == 0 || $urandom_range(0, 1) == 1, win_pick[WIN_W-1:0],
                floor_pick[THRESH_W-1:0]);
      if (p == RANDOM_PHASES - 1) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
        recv_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
      end
      near = thr_half;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
          // Half the readings sit near the threshold so the alarm toggles.
          if ($urandom_range(0, 1) == 1) begin
            adc_pick = near + int'($urandom_range(0, 16)) - 8;
            if (adc_pick < 0) adc_pick = 0;
            if (adc_pick > ADC_FULL) adc_pick = ADC_FULL;
          end else begin
            adc_pick = $urandom_range(0, ADC_FULL);
          end
          add_item(CMD_SAMPLE, adc_pick);
        end else if (roll < 80) begin
          add_item(CMD_UP, $urandom_range(0, ADC_FULL));
        end else if (roll < 95) begin
          add_item(CMD_DOWN, $urandom_range(0, ADC_FULL));
        end else begin
          add_item(CMD_NONE, $urandom_range(0, ADC_FULL));
        end
      end
      settle();
    end

    repeat (100) @(posedge clk);
    if (fault_count == 0) begin
      $display("temperature_average_alarm_test: PASS");
    end else begin
      $display("temperature_average_alarm_test: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("temperature_average_alarm_test: FAIL");
    $finish;
  end

endmodule
